// File: sv/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants of the process-tagged TLB and page table unit.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int TLB_ENTRIES_DEF    = 8;
    localparam int PROCESSES_DEF      = 4;
    localparam int MAX_PAGE_BITS_DEF  = 8;
    localparam int MAX_FRAME_BITS_DEF = 8;

    // Operation codes.
    localparam logic [2:0] OP_MAP     = 3'd0;
    localparam logic [2:0] OP_UNMAP   = 3'd1;
    localparam logic [2:0] OP_XLATE   = 3'd2;
    localparam logic [2:0] OP_PG_INSP = 3'd3;
    localparam logic [2:0] OP_TLB_INSP = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_OFFSET_BITS = 1'd0;
    localparam logic [0:0] CFG_VPN_BITS    = 1'd1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;   // take the input item and start the page table read
        logic execute;   // update state and form the result
        logic clear_en;  // clear sweep step on the page valid store
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

// File: sv/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB slots, page table memories, configuration registers and result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
    parameter int TLB_ENTRIES    = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PROCESSES      = tlbpt_pkg::PROCESSES_DEF,
    parameter int MAX_PAGE_BITS  = tlbpt_pkg::MAX_PAGE_BITS_DEF,
    parameter int MAX_FRAME_BITS = tlbpt_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlbpt_pkg::t_cmd  i_cmd,
    output tlbpt_pkg::t_sts  o_sts,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [3:0]       i_cfg_data,
    input  logic [2:0]       i_operation,
    input  logic [1:0]       i_pid,
    input  logic [7:0]       i_vpn,
    input  logic [7:0]       i_frame,
    input  logic [7:0]       i_page_offset,
    input  logic [2:0]       i_tlb_index,
    output logic [1:0]       o_status,
    output logic             o_tlb_hit,
    output logic [2:0]       o_slot,
    output logic [7:0]       o_frame_out,
    output logic             o_entry_valid,
    output logic [7:0]       o_vpn_out,
    output logic [1:0]       o_pid_out,
    output logic [15:0]      o_physical_address
);
    import tlbpt_pkg::*;

    localparam int SW = $clog2(TLB_ENTRIES);
    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int AW = PW + MAX_PAGE_BITS;
    localparam int DEPTH = PROCESSES * (2 ** MAX_PAGE_BITS);
    localparam int FW = MAX_FRAME_BITS;
    localparam logic [3:0] MAXPB = 4'(MAX_PAGE_BITS);

    // Configuration registers.
    logic [3:0] r_offset_bits, r_vpn_bits;

    // TLB slots.
    logic [TLB_ENTRIES-1:0]           r_tv;
    logic [MAX_PAGE_BITS-1:0]         r_tpage [TLB_ENTRIES];
    logic [FW-1:0]                    r_tframe[TLB_ENTRIES];
    logic [PW-1:0]                    r_tproc [TLB_ENTRIES];

    // Page table memories.
    logic          r_pvalid[DEPTH];
    logic [FW-1:0] r_pframe[DEPTH];
    logic          r_pv_rd;
    logic [FW-1:0] r_pf_rd;
    logic [AW-1:0] r_clr_addr;

    // Captured item.
    logic [2:0]  r_op;
    logic [PW-1:0] r_pid;
    logic [7:0]  r_vpn;
    logic [FW-1:0] r_frame;
    logic [7:0]  r_poff;
    logic [SW-1:0] r_tix;
    logic        r_in_range;
    logic [AW-1:0] r_pidx;

    logic [PW-1:0] w_pid;
    logic [3:0]  w_vb;
    logic [3:0]  w_ob;
    logic        w_in_range;
    logic [AW-1:0] w_pidx;

    always_comb begin
        w_pid = (PROCESSES > 1) ? PW'({28'd0, i_pid} % PROCESSES) : '0;
        w_vb  = (r_vpn_bits > MAXPB) ? MAXPB : r_vpn_bits;
        w_in_range = ({8'd0, i_vpn} >> w_vb) == 16'd0;
        w_pidx = {w_pid, i_vpn[MAX_PAGE_BITS-1:0]};
        w_ob  = (r_offset_bits > 4'd8) ? 4'd8 : r_offset_bits;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd4;
            r_vpn_bits    <= 4'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_OFFSET_BITS) r_offset_bits <= i_cfg_data;
            else r_vpn_bits <= i_cfg_data;
        end
    end

    // Capture of the item and registered page table read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_operation;
            r_pid      <= w_pid;
            r_vpn      <= i_vpn;
            r_frame    <= FW'(i_frame);
            r_poff     <= i_page_offset;
            r_tix      <= SW'({29'd0, i_tlb_index} % TLB_ENTRIES);
            r_in_range <= w_in_range;
            r_pidx     <= w_pidx;
            r_pv_rd    <= r_pvalid[w_pidx];
            r_pf_rd    <= r_pframe[w_pidx];
        end
    end

    // TLB associative match and first free slot.
    logic          w_hit, w_free;
    logic [SW-1:0] w_hit_ix, w_free_ix;
    always_comb begin
        w_hit = 1'b0; w_hit_ix = '0; w_free = 1'b0; w_free_ix = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tv[i] && r_tpage[i] == r_vpn[MAX_PAGE_BITS-1:0] && r_tproc[i] == r_pid) begin
                w_hit = 1'b1; w_hit_ix = SW'(i);
            end
            if (!r_tv[i]) begin
                w_free = 1'b1; w_free_ix = SW'(i);
            end
        end
    end

    logic w_act;
    assign w_act = i_cmd.execute && r_in_range;

    // Page table writes and clear sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_pvalid[r_clr_addr] <= 1'b0;
        end else if (w_act && r_op == OP_MAP) begin
            r_pvalid[r_pidx] <= 1'b1;
            r_pframe[r_pidx] <= r_frame;
        end else if (w_act && r_op == OP_UNMAP) begin
            r_pvalid[r_pidx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.clear_en) r_clr_addr <= r_clr_addr + AW'(1);
    end
    assign o_sts.clear_last = (r_clr_addr == AW'(DEPTH - 1));

    // TLB updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_tpage[i] <= '0; r_tframe[i] <= '0; r_tproc[i] <= '0;
            end
        end else if (w_act) begin
            if (r_op == OP_MAP) begin
                if (w_hit) r_tframe[w_hit_ix] <= r_frame;
                else if (w_free) begin
                    r_tv[w_free_ix] <= 1'b1;
                    r_tpage[w_free_ix] <= r_vpn[MAX_PAGE_BITS-1:0];
                    r_tframe[w_free_ix] <= r_frame;
                    r_tproc[w_free_ix] <= r_pid;
                end
            end else if (r_op == OP_UNMAP) begin
                if (w_hit) r_tv[w_hit_ix] <= 1'b0;
            end else if (r_op == OP_XLATE) begin
                if (!w_hit && r_pv_rd && w_free) begin
                    r_tv[w_free_ix] <= 1'b1;
                    r_tpage[w_free_ix] <= r_vpn[MAX_PAGE_BITS-1:0];
                    r_tframe[w_free_ix] <= r_pf_rd;
                    r_tproc[w_free_ix] <= r_pid;
                end
            end
        end
    end

    // Result register.
    logic [FW-1:0] w_xf;
    logic [7:0]    w_mask;
    assign w_xf   = w_hit ? r_tframe[w_hit_ix] : r_pf_rd;
    assign w_mask = 8'((9'd1 << w_ob) - 9'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            o_status <= ST_OK; o_tlb_hit <= 1'b0; o_slot <= '0; o_frame_out <= '0;
            o_entry_valid <= 1'b0; o_vpn_out <= '0; o_pid_out <= '0;
            o_physical_address <= '0;
            if (r_op == OP_TLB_INSP) begin
                o_frame_out   <= 8'(r_tframe[r_tix]);
                o_entry_valid <= r_tv[r_tix];
                o_vpn_out     <= 8'(r_tpage[r_tix]);
                o_pid_out     <= 2'(r_tproc[r_tix]);
            end else if (r_op <= OP_PG_INSP) begin
                if (!r_in_range) o_status <= ST_RANGE;
                else if (r_op == OP_XLATE) begin
                    if (!w_hit && !r_pv_rd) o_status <= ST_NO_PAGE;
                    else begin
                        o_tlb_hit <= w_hit;
                        o_slot <= w_hit ? 3'(w_hit_ix) : 3'd0;
                        o_frame_out <= 8'(w_xf);
                        o_physical_address <= (16'(w_xf) << w_ob) | {8'd0, r_poff & w_mask};
                    end
                end else if (r_op == OP_PG_INSP && r_pv_rd) begin
                    o_frame_out <= 8'(r_pf_rd);
                    o_entry_valid <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Controller: clear sweep after reset, then read, execute and deliver steps.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output tlbpt_pkg::t_cmd o_cmd,
    input  tlbpt_pkg::t_sts i_sts
);
    import tlbpt_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_OUT} t_state;
    t_state r_state;

    // The item is taken when no result waits; then it executes next cycle.
    assign o_ready = (r_state == S_IDLE) || (r_state == S_OUT && i_ready);
    assign o_cmd.capture  = i_valid && o_ready;
    assign o_cmd.execute  = (r_state == S_EXEC);
    assign o_cmd.clear_en = (r_state == S_CLEAR);
    assign o_valid = (r_state == S_OUT);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_sts.clear_last) r_state <= S_IDLE;
                S_IDLE:  if (i_valid) r_state <= S_EXEC;
                S_EXEC:  r_state <= S_OUT;
                S_OUT: begin
                    if (i_ready) r_state <= i_valid ? S_EXEC : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/tlb_with_page_table_unit.sv
// ----------------------------------------------------------------------------
// tlb_with_page_table_unit
// Process-tagged fully associative TLB with a linear page table per process.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         operation, pid, vpn, frame, ...
// result    out        o_valid / i_ready         status, tlb_hit, slot, ...
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// An item passes through a registered page table read, then a step that
// updates the TLB and page table and registers the result.
// After reset a clear pass over all PROCESSES * 2^MAX_PAGE_BITS entries (1024
// by default) sweeps the page valid store; no item is taken meanwhile.
// A result held by a stalled output blocks the next item until it is taken.
module tlb_with_page_table_unit #(
    parameter int TLB_ENTRIES    = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PROCESSES      = tlbpt_pkg::PROCESSES_DEF,
    parameter int MAX_PAGE_BITS  = tlbpt_pkg::MAX_PAGE_BITS_DEF,
    parameter int MAX_FRAME_BITS = tlbpt_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [1:0]  i_pid,
    input  logic [7:0]  i_vpn,
    input  logic [7:0]  i_frame,
    input  logic [7:0]  i_page_offset,
    input  logic [2:0]  i_tlb_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_tlb_hit,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_frame_out,
    output logic        o_entry_valid,
    output logic [7:0]  o_vpn_out,
    output logic [1:0]  o_pid_out,
    output logic [15:0] o_physical_address
);
    import tlbpt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tlbpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    tlbpt_datapath #(
        .TLB_ENTRIES(TLB_ENTRIES), .PROCESSES(PROCESSES),
        .MAX_PAGE_BITS(MAX_PAGE_BITS), .MAX_FRAME_BITS(MAX_FRAME_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_pid(i_pid), .i_vpn(i_vpn), .i_frame(i_frame),
        .i_page_offset(i_page_offset), .i_tlb_index(i_tlb_index),
        .o_status(o_status), .o_tlb_hit(o_tlb_hit), .o_slot(o_slot),
        .o_frame_out(o_frame_out), .o_entry_valid(o_entry_valid),
        .o_vpn_out(o_vpn_out), .o_pid_out(o_pid_out),
        .o_physical_address(o_physical_address)
    );
endmodule

// File: sv/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks on the TLB and page table unit.
// ----------------------------------------------------------------------------
module tlbpt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic        o_tlb_hit
);
    // A stalled result keeps its status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_status)) else $error("result changed");

    // An accepted item gives a result after its execute state.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> ##1 o_valid) else $error("result missing");

    // No item is taken while a result waits unaccepted.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready) else $error("item taken over result");

    // A hit never carries an error status.
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tlb_hit |-> o_status == 2'd0) else $error("hit with error");
endmodule

bind tlb_with_page_table_unit tlbpt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_tlb_hit(o_tlb_hit)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the process-tagged TLB and page table unit. A local
// model of the TLB and page tables predicts each result; a scoreboard class
// holds the predictions and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tlbpt_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        tlb_hit;
        logic [2:0]  slot;
        logic [7:0]  frame_out;
        logic        entry_valid;
        logic [7:0]  vpn_out;
        logic [1:0]  pid_out;
        logic [15:0] phys;
    } t_xlat_res;

    // Translation model and the queue of predicted results.
    class xlat_scoreboard;
        logic        tv [8];
        logic [7:0]  tp [8];
        logic [7:0]  tf [8];
        logic [1:0]  tq [8];
        logic        pv [1024];
        logic [7:0]  pf [1024];
        logic [3:0]  off_bits;
        logic [3:0]  page_bits;
        t_xlat_res   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 8; i++) begin
                tv[i] = 0; tp[i] = 0; tf[i] = 0; tq[i] = 0;
            end
            for (int i = 0; i < 1024; i++) begin
                pv[i] = 0; pf[i] = 0;
            end
            off_bits = 4; page_bits = 4; errors = 0;
        endfunction

        function int lookup(logic [7:0] v, logic [1:0] p);
            for (int i = 0; i < 8; i++)
                if (tv[i] && tp[i] == v && tq[i] == p) return i;
            return -1;
        endfunction

        function void fill(logic [7:0] v, logic [7:0] f, logic [1:0] p);
            for (int i = 0; i < 8; i++)
                if (!tv[i]) begin
                    tv[i] = 1; tp[i] = v; tf[i] = f; tq[i] = p;
                    return;
                end
        endfunction

        // Notes an accepted input item and predicts its result.
        function void note_item(logic [2:0] op, logic [1:0] p, logic [7:0] v,
                                logic [7:0] f, logic [7:0] po, logic [2:0] ti);
            t_xlat_res r;
            int k, vb, ob, idx;
            logic [7:0] fr;
            r = '0;
            vb = (page_bits > 8) ? 8 : page_bits;
            ob = (off_bits > 8) ? 8 : off_bits;
            idx = p * 256 + v;
            if (op == OP_TLB_INSP) begin
                r.frame_out = tf[ti]; r.entry_valid = tv[ti];
                r.vpn_out = tp[ti]; r.pid_out = tq[ti];
            end else if (op > OP_TLB_INSP) begin
            end else if (v >= (1 << vb)) begin
                r.status = ST_RANGE;
            end else if (op == OP_MAP) begin
                pv[idx] = 1; pf[idx] = f;
                k = lookup(v, p);
                if (k >= 0) tf[k] = f;
                else fill(v, f, p);
            end else if (op == OP_UNMAP) begin
                pv[idx] = 0;
                k = lookup(v, p);
                if (k >= 0) tv[k] = 0;
            end else if (op == OP_XLATE) begin
                k = lookup(v, p);
                if (k >= 0) begin
                    fr = tf[k]; r.tlb_hit = 1; r.slot = k[2:0];
                end else if (!pv[idx]) begin
                    r.status = ST_NO_PAGE;
                end else begin
                    fr = pf[idx]; fill(v, fr, p);
                end
                if (r.status == ST_OK) begin
                    r.frame_out = fr;
                    r.phys = 16'(({8'd0, fr} << ob) | (po & ((1 << ob) - 1)));
                end
            end else if (pv[idx]) begin
                r.frame_out = pf[idx]; r.entry_valid = 1;
            end
            pending.push_back(r);
        endfunction

        // Compares one result with the oldest prediction.
        function void check_result(t_xlat_res a);
            t_xlat_res e;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status != e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.tlb_hit != e.tlb_hit) begin
                $error("tlb_hit exp %0d got %0d", e.tlb_hit, a.tlb_hit); errors++;
            end
            if (a.slot != e.slot) begin
                $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
            end
            if (a.frame_out != e.frame_out) begin
                $error("frame_out exp %0d got %0d", e.frame_out, a.frame_out); errors++;
            end
            if (a.entry_valid != e.entry_valid) begin
                $error("entry_valid exp %0d got %0d", e.entry_valid, a.entry_valid);
                errors++;
            end
            if (a.vpn_out != e.vpn_out) begin
                $error("vpn_out exp %0d got %0d", e.vpn_out, a.vpn_out); errors++;
            end
            if (a.pid_out != e.pid_out) begin
                $error("pid_out exp %0d got %0d", e.pid_out, a.pid_out); errors++;
            end
            if (a.phys != e.phys) begin
                $error("physical_address exp %0d got %0d", e.phys, a.phys); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [0:0]  i_cfg_index = 0;
    logic [3:0]  i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_operation = 0;
    logic [1:0]  i_pid = 0;
    logic [7:0]  i_vpn = 0;
    logic [7:0]  i_frame = 0;
    logic [7:0]  i_page_offset = 0;
    logic [2:0]  i_tlb_index = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic        o_tlb_hit;
    logic [2:0]  o_slot;
    logic [7:0]  o_frame_out;
    logic        o_entry_valid;
    logic [7:0]  o_vpn_out;
    logic [1:0]  o_pid_out;
    logic [15:0] o_physical_address;

    tlb_with_page_table_unit dut (.*);

    always #1 i_clk = ~i_clk;

    xlat_scoreboard sb = new();
    int send_idle = 14;
    int recv_idle = 51;
    int cycles = 0;
    int pool_v [4];

    // Result side: stall at random and check each accepted result.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_status, o_tlb_hit, o_slot, o_frame_out, o_entry_valid,
                             o_vpn_out, o_pid_out, o_physical_address});
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle);

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_OFFSET_BITS) sb.off_bits = val;
        else sb.page_bits = val;
    endtask

    // Presents one item and waits until it is taken. Valid drops only while
    // the sender idles, so items may follow each other with no gap.
    task automatic send_item(logic [2:0] op, logic [1:0] p, logic [7:0] v,
                             logic [7:0] f, logic [7:0] po, logic [2:0] ti);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_operation <= op; i_pid <= p; i_vpn <= v;
        i_frame <= f; i_page_offset <= po; i_tlb_index <= ti;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(op, p, v, f, po, ti);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Mostly in-range pages from a small pool, so that hits and refills occur.
    task automatic random_items(int n);
        logic [2:0] op;
        logic [7:0] v;
        int lim;
        for (int i = 0; i < n; i++) begin
            lim = 1 << ((sb.page_bits > 8) ? 8 : sb.page_bits);
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
            case ($urandom_range(9))
                0:       v = 8'($urandom);
                1, 2, 3: v = 8'($urandom_range(lim - 1));
                default: v = 8'(pool_v[$urandom_range(3)] % lim);
            endcase
            send_item(op, 2'($urandom), v, 8'($urandom), 8'($urandom), 3'($urandom));
        end
    endtask

    initial begin
        logic [3:0] ob_set [4] = '{4'd0, 4'd8, 4'd15, 4'd3};
        logic [3:0] vb_set [4] = '{4'd1, 4'd8, 4'd0, 4'd15};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < 4; i++) pool_v[i] = $urandom_range(255);

        // Directed items under reset settings.
        send_item(OP_XLATE, 0, 0, 0, 8'hff, 0);
        send_item(OP_PG_INSP, 0, 3, 0, 0, 0);
        send_item(OP_MAP, 0, 3, 8'hff, 0, 0);
        send_item(OP_XLATE, 0, 3, 0, 8'hff, 0);
        send_item(OP_MAP, 1, 3, 8'h00, 0, 0);
        send_item(OP_XLATE, 1, 3, 0, 8'h5a, 0);
        send_item(OP_PG_INSP, 0, 3, 0, 0, 0);
        send_item(OP_TLB_INSP, 0, 0, 0, 0, 0);
        send_item(OP_MAP, 0, 3, 8'h81, 0, 0);
        send_item(OP_UNMAP, 0, 3, 0, 0, 0);
        send_item(OP_TLB_INSP, 0, 0, 0, 0, 7);
        send_item(OP_TLB_INSP, 0, 0, 0, 0, 0);
        send_item(OP_XLATE, 0, 3, 0, 0, 0);
        send_item(OP_MAP, 3, 15, 8'h7e, 0, 0);
        send_item(OP_MAP, 3, 16, 8'h11, 0, 0);
        send_item(OP_XLATE, 2, 8'hff, 0, 0, 0);
        send_item(OP_UNMAP, 2, 8'hff, 0, 0, 0);
        send_item(OP_PG_INSP, 2, 8'hff, 0, 0, 0);
        send_item(3'd7, 3, 8'hff, 8'hff, 8'hff, 7);
        send_item(3'd5, 0, 0, 0, 0, 0);
        // Fill every slot, then miss with the TLB full.
        for (int i = 0; i < 8; i++) send_item(OP_MAP, 2, 8'(i), 8'(i + 40), 0, 0);
        send_item(OP_MAP, 2, 9, 8'h33, 0, 0);
        send_item(OP_XLATE, 2, 9, 0, 8'h0f, 0);
        drain();

        // Random phases over several register settings and idling patterns.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin send_idle = 51; recv_idle = 14; end
            if (ph == 8) begin send_idle = 0; recv_idle = 0; end
            write_reg(CFG_OFFSET_BITS, ob_set[ph % 4]);
            write_reg(CFG_VPN_BITS, (ph % 3 == 0) ? 4'($urandom_range(2, 4))
                                                  : vb_set[(ph / 3) % 4]);
            random_items(85);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
